/* design/mep_pkg.sv */
// Shared types, constants and helpers for the Mandelbrot escape-time pixel block.
`default_nettype none

package mep_pkg;

    // Configuration port geometry
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_REAL_START = 2'd0;
    localparam logic [1:0] REG_IMAG_START = 2'd1;
    localparam logic [1:0] REG_REAL_STEP  = 2'd2;
    localparam logic [1:0] REG_IMAG_STEP  = 2'd3;

    // Reset values (signed Q4.28)
    localparam logic signed [31:0] RST_REAL_START = 32'shE000_0000;  // -2.0
    localparam logic signed [31:0] RST_IMAG_START = 32'shF000_0000;  // -1.0
    localparam logic signed [31:0] RST_REAL_STEP  = 32'sh000D_AE54;
    localparam logic signed [31:0] RST_IMAG_STEP  = 32'sh000D_AE54;

    // Width of index*step + start before saturation
    localparam int MAP_W = 44;

    typedef struct packed {
        logic [9:0] column;
        logic [9:0] row;
    } pixel_t;

    typedef struct packed {
        logic [6:0] escape_count;
        logic [7:0] green_level;
    } result_t;

    typedef struct packed {
        logic signed [31:0] real_start;
        logic signed [31:0] imag_start;
        logic signed [31:0] real_step;
        logic signed [31:0] imag_step;
    } cfg_t;

    // Multiplier unit operand selection
    typedef enum logic {
        MUL_MAP    = 1'b0,   // index * step
        MUL_SQUARE = 1'b1    // re*re, im*im, re*im
    } mul_op_t;

    typedef struct packed {
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
    } prod_t;

    // Clip to signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [MAP_W-1:0] v);
        logic signed [31:0] r;
        if (v[MAP_W-1:31] == '0 || v[MAP_W-1:31] == '1)
        begin
            r = v[31:0];
        end
        else if (v[MAP_W-1])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/mep_regs.sv */
// APB configuration registers: plane origin and per-pixel step.
`default_nettype none

module mep_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mep_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mep_pkg::DATA_W-1:0]  pwdata,
    output logic      [mep_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output mep_pkg::cfg_t                    cfg
);

    logic signed [31:0] real_start_reg;
    logic signed [31:0] imag_start_reg;
    logic signed [31:0] real_step_reg;
    logic signed [31:0] imag_step_reg;
    logic               wr_en;
    logic [1:0]         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_start_reg <= mep_pkg::RST_REAL_START;
            imag_start_reg <= mep_pkg::RST_IMAG_START;
            real_step_reg  <= mep_pkg::RST_REAL_STEP;
            imag_step_reg  <= mep_pkg::RST_IMAG_STEP;
        end
        else if (wr_en)
        begin
            case (idx)
                mep_pkg::REG_REAL_START: real_start_reg <= $signed(pwdata);
                mep_pkg::REG_IMAG_START: imag_start_reg <= $signed(pwdata);
                mep_pkg::REG_REAL_STEP:  real_step_reg  <= $signed(pwdata);
                mep_pkg::REG_IMAG_STEP:  imag_step_reg  <= $signed(pwdata);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            mep_pkg::REG_REAL_START: prdata = real_start_reg;
            mep_pkg::REG_IMAG_START: prdata = imag_start_reg;
            mep_pkg::REG_REAL_STEP:  prdata = real_step_reg;
            mep_pkg::REG_IMAG_STEP:  prdata = imag_step_reg;
            default:                 prdata = '0;
        endcase
    end

    assign cfg.real_start = real_start_reg;
    assign cfg.imag_start = imag_start_reg;
    assign cfg.real_step  = real_step_reg;
    assign cfg.imag_step  = imag_step_reg;

endmodule

`default_nettype wire

/* design/mep_cmul.sv */
// Shared multiplier unit: three 32x32 signed products, registered outputs.
`default_nettype none

module mep_cmul (
    input  wire logic                clk,
    input  wire mep_pkg::mul_op_t    op,
    input  wire logic signed [31:0]  re,
    input  wire logic signed [31:0]  im,
    input  wire logic        [9:0]   col,
    input  wire logic        [9:0]   row,
    input  wire logic signed [31:0]  real_step,
    input  wire logic signed [31:0]  imag_step,
    output mep_pkg::prod_t           prod
);

    logic signed [31:0] a0, b0, a1, b1;
    mep_pkg::prod_t     prod_reg;
    mep_pkg::prod_t     prod_next;

    always_comb
    begin
        case (op)
            mep_pkg::MUL_MAP:
            begin
                a0 = $signed({22'd0, col});
                b0 = real_step;
                a1 = $signed({22'd0, row});
                b1 = imag_step;
            end
            default:
            begin
                a0 = re;
                b0 = re;
                a1 = im;
                b1 = im;
            end
        endcase
        prod_next.p0 = 64'(a0) * 64'(b0);
        prod_next.p1 = 64'(a1) * 64'(b1);
        prod_next.p2 = 64'(re) * 64'(im);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* design/mandelbrot_escape_pixel.sv */
// Top level: Mandelbrot escape-time evaluator for one pixel per transaction.
//
// Usage
//   Input: drive pixel (column, row) and raise start. The transaction is
//   taken at a rising edge with start high and busy low; busy then stays
//   high until the result is out.
//   Output: done is high for exactly one cycle with result (escape_count,
//   green_level). The receiver cannot stall; the result must be taken then.
//   Config: APB registers real_start, imag_start, real_step, imag_step at
//   byte addresses 0, 4, 8, 12 (signed Q4.28). pready is tied high. Write
//   them only while busy is low and no result is pending.
// Sequence
//   The point is formed first (index*step on the shared multipliers, then
//   add and clip). Each escape check has the multiplier unit form re*re,
//   im*im, re*im, after which the registered products test the magnitude
//   and update the iterate. There are at most MAX_ITER checks (85 by
//   default). done rises after the last check and busy drops together with
//   it; a new pixel may be taken at the edge that ends the done cycle.
// Reset
//   rst_n clears the sequencer and reloads the register reset values; any
//   pixel in flight is dropped.
`default_nettype none

module mandelbrot_escape_pixel #(
    parameter int MAX_ITER  = 85,
    parameter int DIM_MAX   = 1024,
    parameter int FRAC_BITS = 28
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // pixel channel
    input  wire logic                        start,
    output logic                             busy,
    input  wire mep_pkg::pixel_t             pixel,
    // result channel
    output logic                             done,
    output mep_pkg::result_t                 result,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mep_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [mep_pkg::DATA_W-1:0]  pwdata,
    output logic      [mep_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    // Iteration counter width: holds 0..MAX_ITER
    localparam int CW      = $clog2(MAX_ITER + 1);
    localparam int GW      = (CW + 2 > 9) ? CW + 2 : 9;
    localparam int EW      = (CW > 7) ? CW : 7;
    // Magnitude^2 >= 4 in Q(2*FRAC_BITS) means any bit at or above this is set
    localparam int ESC_LSB = 2 * FRAC_BITS + 2;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,   // wait for start
        S_MAP    = 4'b0010,   // index * step in the multiplier unit
        S_ORIGIN = 4'b0100,   // c = start + product, clipped
        S_MUL    = 4'b1000    // squares in flight; test/update follows
    } state_t;

    // S_MUL alternates with a test cycle tracked by phase_reg
    state_t             state_reg, state_next;
    logic               phase_reg, phase_next;    // 1: test/update cycle
    logic [CW-1:0]      k_reg, k_next;
    logic               done_reg, done_next;

    logic [9:0]         col_reg, col_next;
    logic [9:0]         row_reg, row_next;
    logic signed [31:0] cre_reg, cre_next;
    logic signed [31:0] cim_reg, cim_next;
    logic signed [31:0] re_reg, re_next;
    logic signed [31:0] im_reg, im_next;
    mep_pkg::result_t   result_reg, result_next;

    mep_pkg::cfg_t      cfg;
    mep_pkg::prod_t     prod;
    mep_pkg::mul_op_t   mul_op;

    logic               accept;
    logic [9:0]         col_clamp, row_clamp;
    logic [63:0]        mag2;
    logic               escape;
    logic               last_check;
    logic signed [63:0] diff;
    logic signed [63:0] sh_re, sh_im;
    logic signed [33:0] nre, nim;
    logic [CW-1:0]      count_fin;
    logic [GW-1:0]      g3;
    logic [EW-1:0]      count_ext;

    mep_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign mul_op = (state_reg == S_MAP) ? mep_pkg::MUL_MAP : mep_pkg::MUL_SQUARE;

    mep_cmul u_cmul (
        .clk       (clk),
        .op        (mul_op),
        .re        (re_reg),
        .im        (im_reg),
        .col       (col_reg),
        .row       (row_reg),
        .real_step (cfg.real_step),
        .imag_step (cfg.imag_step),
        .prod      (prod)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Indices past the image edge stick to the last column/row
    always_comb
    begin
        col_clamp = pixel.column;
        row_clamp = pixel.row;
        if (32'(pixel.column) >= 32'(DIM_MAX))
        begin
            col_clamp = 10'(DIM_MAX - 1);
        end
        if (32'(pixel.row) >= 32'(DIM_MAX))
        begin
            row_clamp = 10'(DIM_MAX - 1);
        end
    end

    // Escape test and iterate update from the registered products.
    // Update is only used when |u| < 2, so the shifted terms stay small.
    always_comb
    begin
        mag2       = $unsigned(prod.p0) + $unsigned(prod.p1);
        escape     = |mag2[63:ESC_LSB];
        last_check = (k_reg == CW'(MAX_ITER - 1));
        diff       = prod.p0 - prod.p1;
        sh_re      = diff >>> FRAC_BITS;
        sh_im      = prod.p2 >>> (FRAC_BITS - 1);   // 2*re*im
        nre        = 34'(sh_re) + 34'(cre_reg);
        nim        = 34'(sh_im) + 34'(cim_reg);
    end

    // Result formatting
    always_comb
    begin
        count_fin = escape ? CW'(k_reg + CW'(1)) : '0;
        g3        = (GW'(count_fin) << 1) + GW'(count_fin);
        count_ext = EW'(count_fin);
        result_next.escape_count = count_ext[6:0];
        result_next.green_level  = (g3 > GW'(255)) ? 8'hFF : g3[7:0];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        col_next   = col_reg;
        row_next   = row_reg;
        cre_next   = cre_reg;
        cim_next   = cim_reg;
        re_next    = re_reg;
        im_next    = im_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    col_next   = col_clamp;
                    row_next   = row_clamp;
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                state_next = S_ORIGIN;
            end
            S_ORIGIN:
            begin
                cre_next   = mep_pkg::sat32(mep_pkg::MAP_W'(cfg.real_start)
                                            + mep_pkg::MAP_W'(prod.p0));
                cim_next   = mep_pkg::sat32(mep_pkg::MAP_W'(cfg.imag_start)
                                            + mep_pkg::MAP_W'(prod.p1));
                re_next    = cre_next;
                im_next    = cim_next;
                k_next     = '0;
                phase_next = 1'b0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (!phase_reg)
                begin
                    // products of the current iterate land this edge
                    phase_next = 1'b1;
                end
                else if (escape || last_check)
                begin
                    done_next  = 1'b1;
                    phase_next = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    re_next    = mep_pkg::sat32(mep_pkg::MAP_W'(nre));
                    im_next    = mep_pkg::sat32(mep_pkg::MAP_W'(nim));
                    k_next     = CW'(k_reg + CW'(1));
                    phase_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                phase_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        row_reg <= row_next;
        cre_reg <= cre_next;
        cim_reg <= cim_next;
        re_reg  <= re_next;
        im_reg  <= im_next;
        if (done_next)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

/* design/mep_checker.sv */
// Port-level checker for the escape-time pixel block, bound to the top level.
`default_nettype none

module mep_checker #(
    parameter int MAX_ITER = 85
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire mep_pkg::result_t result
);

    logic [8:0] g3;

    assign g3 = 9'(result.escape_count) * 9'd3;

    // a taken transaction makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    // busy ends exactly when the result is shown
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // green is 3*count clipped, when the count is not masked
    a_green: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (MAX_ITER >= 128) ||
                 (result.green_level == ((g3 > 9'd255) ? 8'hFF : g3[7:0])))
        else $error("green level does not match escape count");

endmodule

bind mandelbrot_escape_pixel mep_checker #(.MAX_ITER(MAX_ITER)) u_mep_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
